// File: design/kmhr_pkg.sv
// shared constants and types for the key matrix to hid report block
`timescale 1ns / 1ps
`default_nettype none
package kmhr_pkg;

  localparam int MATRIX_KEYS  = 48;
  localparam int LAYERS       = 2;
  localparam int REPORT_SLOTS = 6;
  localparam int MAP_ENTRIES  = MATRIX_KEYS * LAYERS;

  localparam int KEY_IDX_W  = 6;
  localparam int MAP_IDX_W  = 7;
  localparam int CNT_W      = $clog2(REPORT_SLOTS + 1);
  localparam int SLOT_IDX_W = (REPORT_SLOTS > 1) ? $clog2(REPORT_SLOTS) : 1;

  localparam int KBD_LEN    = 3 + REPORT_SLOTS;
  localparam int MOUSE_LEN  = 9;
  localparam int FRAME_MAX  = (KBD_LEN > MOUSE_LEN) ? KBD_LEN : MOUSE_LEN;
  localparam int BYTE_CNT_W = $clog2(FRAME_MAX);

  // input operations
  localparam logic [1:0] OP_KEY = 2'd0;
  localparam logic [1:0] OP_EOS = 2'd1;
  localparam logic [1:0] OP_MAP = 2'd2;

  // keymap entry modes
  localparam logic [1:0] MODE_KEY     = 2'd0;
  localparam logic [1:0] MODE_MOD     = 2'd1;
  localparam logic [1:0] MODE_SPECIAL = 2'd2;
  localparam logic [1:0] MODE_OFF     = 2'd3;

  // special action codes
  localparam logic [7:0] SPC_LAYER   = 8'd1;
  localparam logic [7:0] SPC_CLICK_L = 8'd6;
  localparam logic [7:0] SPC_CLICK_R = 8'd7;

  localparam logic [7:0] FRAME_START = 8'hFD;
  localparam logic [7:0] MOUSE_TAG   = 8'h03;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] code;
  } map_entry_t;

  // one end of scan worth of frame contents
  typedef struct packed {
    logic                         key_changed;
    logic                         mouse_changed;
    logic [7:0]                   modifier;
    logic [REPORT_SLOTS-1:0][7:0] keys;
    logic [1:0]                   click;
    logic [7:0]                   dx;
    logic [7:0]                   dy;
  } scan_snap_t;

endpackage
`default_nettype wire

// File: design/key_matrix_to_hid_report_core.sv
// Key matrix to HID report block.
// The in_ channel takes one item per cycle: key samples, keymap writes and
// end-of-scan items (operation in in_tuser). Key samples and keymap writes
// are taken one per cycle and wait only behind a held end-of-scan item.
// Each end-of-scan item yields a 9-byte keyboard frame and then a 9-byte
// mouse frame, each only if it changed, so 0, 9 or 18 items leave on out_,
// one byte per cycle while out_tready holds high, with out_tuser giving the
// frame kind and out_tlast marking the final byte of the run.
// An end-of-scan item is registered in stage one, its snapshot is written
// to the queue, and the run's first byte is loaded into the output register.
// The keymap memory is read for both layers at once in the accept cycle,
// which keeps one item per cycle across layer changes.
// A two-deep snapshot queue sits between the front end and the serializer.
// When the receiver stalls, bytes hold in the output register and snapshots
// collect in the queue; an end-of-scan item with a change then waits on a
// full queue and in_tready drops until a run is drained.
// Reset (rst_n low, synchronous) clears debounce history, layer, reports and
// the last sent frames; the keymap is not cleared and must be written.
`timescale 1ns / 1ps
`default_nettype none
module key_matrix_to_hid_report_core
  import kmhr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [5:0] key_index, [6] pressed, [14:7] mouse_dx, [22:15] mouse_dy,
  // [29:23] map_index, [31:30] map_mode, [39:32] map_code
  input  wire logic [39:0] in_tdata,
  // [1:0] operation
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] report_byte
  output logic [7:0]       out_tdata,
  // [0] report_kind
  output logic             out_tuser,
  output logic             out_tlast
);

  logic       q_push;
  scan_snap_t q_push_data;
  logic       q_full;
  logic       q_pop;
  scan_snap_t q_head;
  logic       q_head_valid;

  kmhr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (in_tuser),
    .in_key_index (in_tdata[5:0]),
    .in_pressed   (in_tdata[6]),
    .in_dx        (in_tdata[14:7]),
    .in_dy        (in_tdata[22:15]),
    .in_map_index (in_tdata[29:23]),
    .in_map_mode  (in_tdata[31:30]),
    .in_map_code  (in_tdata[39:32]),
    .push         (q_push),
    .push_data    (q_push_data),
    .push_full    (q_full)
  );

  kmhr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  kmhr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_kind   (out_tuser),
    .out_last   (out_tlast)
  );

endmodule
`default_nettype wire

// File: design/kmhr_front.sv
// front end: accepts items, keymap lookup, debounce and report building
`timescale 1ns / 1ps
`default_nettype none
module kmhr_front
  import kmhr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [1:0]           in_op,
  input  wire logic [KEY_IDX_W-1:0] in_key_index,
  input  wire logic                 in_pressed,
  input  wire logic [7:0]           in_dx,
  input  wire logic [7:0]           in_dy,
  input  wire logic [MAP_IDX_W-1:0] in_map_index,
  input  wire logic [1:0]           in_map_mode,
  input  wire logic [7:0]           in_map_code,
  output logic                      push,
  output scan_snap_t                push_data,
  input  wire logic                 push_full
);

  map_entry_t keymap [MAP_ENTRIES];

  logic                 in_fire;
  logic                 in_key_ok;
  logic [MAP_IDX_W-1:0] addr0;
  logic [MAP_IDX_W-1:0] addr1;

  // stage one registers
  logic                 s1_valid_r, s1_valid_nxt;
  logic [1:0]           s1_op_r;
  logic [KEY_IDX_W-1:0] s1_id_r;
  logic                 s1_pressed_r;
  logic [7:0]           s1_dx_r;
  logic [7:0]           s1_dy_r;
  map_entry_t           rd0_r;
  map_entry_t           rd1_r;

  // scan state
  logic [MATRIX_KEYS-1:0]       prev_r, prev_nxt;
  logic                         layer_r, layer_nxt;
  logic [REPORT_SLOTS-1:0][7:0] keys_r, keys_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [7:0]                   mod_r, mod_nxt;
  logic [1:0]                   click_r, click_nxt;
  logic [REPORT_SLOTS-1:0][7:0] sent_keys_r, sent_keys_nxt;
  logic [7:0]                   sent_mod_r, sent_mod_nxt;
  logic [1:0]                   sent_click_r, sent_click_nxt;
  logic [7:0]                   sent_dx_r, sent_dx_nxt;
  logic [7:0]                   sent_dy_r, sent_dy_nxt;

  logic       s1_fire;
  logic       key_ok;
  logic       prev;
  logic       held;
  map_entry_t ent;
  logic [7:0] half_dx;
  logic [7:0] half_dy;
  logic       key_changed;
  logic       mouse_changed;
  logic       eos_blocked;

  assign in_fire   = in_valid && in_ready;
  assign in_key_ok = in_key_index < KEY_IDX_W'(MATRIX_KEYS);
  assign addr0     = in_key_ok ? {1'b0, in_key_index} : '0;
  assign addr1     = addr0 + MAP_IDX_W'(MATRIX_KEYS);

  // both layers are read so a layer change by the item ahead needs no stall
  always_ff @(posedge clk) begin
    if (in_fire && in_op == OP_MAP && in_map_index < MAP_IDX_W'(MAP_ENTRIES)) begin
      keymap[in_map_index] <= '{mode: in_map_mode, code: in_map_code};
    end
    if (in_fire) begin
      rd0_r        <= keymap[addr0];
      rd1_r        <= keymap[addr1];
      s1_op_r      <= in_op;
      s1_id_r      <= in_key_index;
      s1_pressed_r <= in_pressed;
      s1_dx_r      <= in_dx;
      s1_dy_r      <= in_dy;
    end
  end

  assign key_ok  = s1_id_r < KEY_IDX_W'(MATRIX_KEYS);
  assign ent     = layer_r ? rd1_r : rd0_r;
  assign prev    = key_ok ? prev_r[s1_id_r] : 1'b0;
  assign held    = s1_pressed_r && prev;
  assign half_dx = {s1_dx_r[7], s1_dx_r[7:1]};
  assign half_dy = {s1_dy_r[7], s1_dy_r[7:1]};

  assign key_changed   = (mod_r != sent_mod_r) || (keys_r != sent_keys_r);
  assign mouse_changed = (click_r != sent_click_r) || (half_dx != sent_dx_r)
                      || (half_dy != sent_dy_r);

  assign eos_blocked = (s1_op_r == OP_EOS) && (key_changed || mouse_changed) && push_full;
  assign s1_fire     = s1_valid_r && !eos_blocked;
  assign in_ready    = !s1_valid_r || s1_fire;

  assign push = s1_fire && (s1_op_r == OP_EOS) && (key_changed || mouse_changed);
  assign push_data = '{key_changed:   key_changed,
                       mouse_changed: mouse_changed,
                       modifier:      mod_r,
                       keys:          keys_r,
                       click:         click_r,
                       dx:            half_dx,
                       dy:            half_dy};

  always_comb begin
    s1_valid_nxt   = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
    prev_nxt       = prev_r;
    layer_nxt      = layer_r;
    keys_nxt       = keys_r;
    count_nxt      = count_r;
    mod_nxt        = mod_r;
    click_nxt      = click_r;
    sent_keys_nxt  = sent_keys_r;
    sent_mod_nxt   = sent_mod_r;
    sent_click_nxt = sent_click_r;
    sent_dx_nxt    = sent_dx_r;
    sent_dy_nxt    = sent_dy_r;
    if (s1_fire) begin
      case (s1_op_r)
        OP_KEY: begin
          if (key_ok) begin
            case (ent.mode)
              MODE_KEY: begin
                if (held && count_r < CNT_W'(REPORT_SLOTS)) begin
                  keys_nxt[count_r[SLOT_IDX_W-1:0]] = ent.code;
                  count_nxt = count_r + CNT_W'(1);
                end
              end
              MODE_MOD: begin
                if (held) mod_nxt = mod_r | ent.code;
              end
              MODE_SPECIAL: begin
                // acts on a stable level: two presses or two releases in a row
                if (s1_pressed_r == prev) begin
                  if (ent.code == SPC_LAYER) begin
                    layer_nxt = s1_pressed_r;
                  end else if (ent.code == SPC_CLICK_L && s1_pressed_r) begin
                    click_nxt[0] = 1'b1;
                  end else if (ent.code == SPC_CLICK_R && s1_pressed_r) begin
                    click_nxt[1] = 1'b1;
                  end
                end
              end
              default: ;
            endcase
            prev_nxt[s1_id_r] = s1_pressed_r;
          end
        end
        OP_EOS: begin
          sent_keys_nxt  = keys_r;
          sent_mod_nxt   = mod_r;
          sent_click_nxt = click_r;
          sent_dx_nxt    = half_dx;
          sent_dy_nxt    = half_dy;
          keys_nxt       = '0;
          count_nxt      = '0;
          mod_nxt        = '0;
          click_nxt      = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      prev_r       <= '0;
      layer_r      <= 1'b0;
      keys_r       <= '0;
      count_r      <= '0;
      mod_r        <= '0;
      click_r      <= '0;
      sent_keys_r  <= '0;
      sent_mod_r   <= '0;
      sent_click_r <= '0;
      sent_dx_r    <= '0;
      sent_dy_r    <= '0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      prev_r       <= prev_nxt;
      layer_r      <= layer_nxt;
      keys_r       <= keys_nxt;
      count_r      <= count_nxt;
      mod_r        <= mod_nxt;
      click_r      <= click_nxt;
      sent_keys_r  <= sent_keys_nxt;
      sent_mod_r   <= sent_mod_nxt;
      sent_click_r <= sent_click_nxt;
      sent_dx_r    <= sent_dx_nxt;
      sent_dy_r    <= sent_dy_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/kmhr_queue.sv
// two-entry queue of end-of-scan snapshots between front and back
`timescale 1ns / 1ps
`default_nettype none
module kmhr_queue
  import kmhr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire scan_snap_t push_data,
  output logic            full,
  input  wire logic       pop,
  output scan_snap_t      head,
  output logic            head_valid
);

  scan_snap_t slots [2];

  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head       = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr_r] <= push_data;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 2'd1;
    else if (pop && !push) count_nxt = count_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/kmhr_back.sv
// back end: serializes keyboard and mouse frames into an output register
`timescale 1ns / 1ps
`default_nettype none
module kmhr_back
  import kmhr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire scan_snap_t head,
  input  wire logic       head_valid,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_kind,
  output logic            out_last
);

  localparam logic [BYTE_CNT_W-1:0] POS_HDR0  = BYTE_CNT_W'(0);
  localparam logic [BYTE_CNT_W-1:0] POS_HDR1  = BYTE_CNT_W'(1);
  localparam logic [BYTE_CNT_W-1:0] POS_HDR2  = BYTE_CNT_W'(2);
  localparam logic [BYTE_CNT_W-1:0] POS_CLICK = BYTE_CNT_W'(3);
  localparam logic [BYTE_CNT_W-1:0] POS_DX    = BYTE_CNT_W'(4);
  localparam logic [BYTE_CNT_W-1:0] POS_DY    = BYTE_CNT_W'(5);

  logic [BYTE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  key_done_r, key_done_nxt;
  logic                  valid_r, valid_nxt;
  logic [7:0]            byte_r;
  logic                  kind_r;
  logic                  last_r;

  logic                  cur_mouse;
  logic                  frame_end;
  logic                  run_last;
  logic                  load;
  logic [BYTE_CNT_W-1:0] kslot;
  logic [7:0]            byte_sel;

  // mouse frame once the keyboard frame is out or was not needed
  assign cur_mouse = key_done_r || !head.key_changed;
  assign frame_end = cur_mouse ? (cnt_r == BYTE_CNT_W'(MOUSE_LEN - 1))
                               : (cnt_r == BYTE_CNT_W'(KBD_LEN - 1));
  assign run_last  = frame_end && (cur_mouse || !head.mouse_changed);
  assign load      = head_valid && (!valid_r || out_ready);
  assign pop       = load && run_last;
  assign kslot     = cnt_r - BYTE_CNT_W'(3);

  always_comb begin
    byte_sel = 8'h00;
    if (cur_mouse) begin
      case (cnt_r)
        POS_HDR0:  byte_sel = FRAME_START;
        POS_HDR2:  byte_sel = MOUSE_TAG;
        POS_CLICK: byte_sel = {6'b0, head.click};
        POS_DX:    byte_sel = head.dx;
        POS_DY:    byte_sel = head.dy;
        default:   byte_sel = 8'h00;
      endcase
    end else begin
      case (cnt_r)
        POS_HDR0: byte_sel = FRAME_START;
        POS_HDR1: byte_sel = head.modifier;
        POS_HDR2: byte_sel = 8'h00;
        default:  byte_sel = head.keys[kslot[SLOT_IDX_W-1:0]];
      endcase
    end
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    key_done_nxt = key_done_r;
    valid_nxt    = out_ready ? 1'b0 : valid_r;
    if (load) begin
      valid_nxt    = 1'b1;
      cnt_nxt      = frame_end ? '0 : cnt_r + BYTE_CNT_W'(1);
      key_done_nxt = frame_end ? !run_last : key_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_sel;
      kind_r <= cur_mouse;
      last_r <= run_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      key_done_r <= 1'b0;
      valid_r    <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      key_done_r <= key_done_nxt;
      valid_r    <= valid_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;

endmodule
`default_nettype wire
